>>> rtl/core/stern_brocot_path_core_defines.svh
// Assertion macros for the Stern-Brocot path core checker.
// Included by the checker file; no other dependencies.
`ifndef STERN_BROCOT_PATH_CORE_DEFINES_SVH
`define STERN_BROCOT_PATH_CORE_DEFINES_SVH

// same-cycle implication, clocked on clock, off during reset
`define SBP_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SBP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/sbp_pkg.sv
// Shared types and constants for the Stern-Brocot path core.
// No dependencies; used by the core and its checker.
package sbp_pkg;

   localparam int MAX_RESULTS = 64;
   localparam int ITEM_CNT_W  = $clog2(MAX_RESULTS);

   typedef struct packed {
      logic [31:0] numerator;
      logic [31:0] denominator;
   } sbp_req_type;

   typedef struct packed {
      logic        direction;
      logic [31:0] run_length;
      logic        last;
      logic        error;
   } sbp_rsp_type;

endpackage

>>> rtl/core/sbp_divider.sv
// Restoring divider, one quotient bit per cycle.
// Standalone; used by stern_brocot_path_core.
module sbp_divider #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);
   localparam int CW = $clog2(WIDTH + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;

   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   diff;
   logic             fits;

   // partial remainder stays below the divisor, so the shifted trial needs one extra bit
   assign trial = {rem_ff, quo_ff[WIDTH-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(WIDTH);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
         quo_in = {quo_ff[WIDTH-2:0], fits};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

>>> rtl/core/stern_brocot_path_core.sv
// Stern-Brocot path encoder: fraction in, run-length path items out.
// Depends on sbp_pkg and sbp_divider.
//
//   channel   ports                       handshake
//   request   start, busy, req_data       taken when start && !busy
//   response  rsp_valid, rsp_data         one-cycle strobe, never stalled
//
// Each run passes through a setup state, then the shared divider resolves one
// quotient bit per cycle and hands the result back. A zero operand or equal
// operands are answered straight from the setup state. busy drops as the last
// item shows.
// Reset is synchronous and returns the core to idle at once.
module stern_brocot_path_core #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  sbp_pkg::sbp_req_type req_data,
   output logic                 rsp_valid,
   output sbp_pkg::sbp_rsp_type rsp_data
);
   import sbp_pkg::*;

   localparam int W = OPERAND_WIDTH;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SETUP  = 2'd1;
   localparam logic [1:0] ST_DIVIDE = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [W-1:0]          num_ff, num_in;
   logic [W-1:0]          den_ff, den_in;
   logic                  dir_ff, dir_in;
   logic [ITEM_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   sbp_rsp_type           rsp_data_ff, rsp_data_in;

   logic                  div_start;
   logic [W-1:0]          div_dividend;
   logic [W-1:0]          div_divisor;
   logic                  div_done;
   logic [W-1:0]          div_quotient;
   logic [W-1:0]          div_remainder;
   logic [W-1:0]          rem_plus;
   logic                  fin;

   sbp_divider #(
      .WIDTH(W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient),
      .remainder(div_remainder)
   );

   // new larger value is remainder + 1; path ends once both sides meet or the item count reaches MAX_RESULTS
   assign rem_plus = div_remainder + W'(1);
   assign fin = (dir_ff ? (rem_plus == den_ff) : (rem_plus == num_ff)) ||
                (cnt_ff == ITEM_CNT_W'(MAX_RESULTS - 1));

   always_comb begin
      state_in     = state_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      dir_in       = dir_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               num_in   = req_data.numerator[W-1:0];
               den_in   = req_data.denominator[W-1:0];
               cnt_in   = '0;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (num_ff == '0 || den_ff == '0 || num_ff == den_ff) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.direction  = 1'b0;
               rsp_data_in.run_length = '0;
               rsp_data_in.last       = 1'b1;
               rsp_data_in.error      = (num_ff == '0) || (den_ff == '0);
               state_in               = ST_IDLE;
            end else begin
               dir_in    = num_ff > den_ff;
               div_start = 1'b1;
               if (num_ff > den_ff) begin
                  div_dividend = num_ff - W'(1);
                  div_divisor  = den_ff;
               end else begin
                  div_dividend = den_ff - W'(1);
                  div_divisor  = num_ff;
               end
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.direction  = dir_ff;
               rsp_data_in.run_length = 32'(div_quotient);
               rsp_data_in.last       = fin;
               rsp_data_in.error      = 1'b0;
               if (dir_ff) begin
                  num_in = rem_plus;
               end else begin
                  den_in = rem_plus;
               end
               cnt_in   = cnt_ff + ITEM_CNT_W'(1);
               state_in = fin ? ST_IDLE : ST_SETUP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      num_ff      <= num_in;
      den_ff      <= den_in;
      dir_ff      <= dir_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/core/stern_brocot_path_core_checker.sv
// Port-level checker for stern_brocot_path_core, bound into stern_brocot_path_core.
// Depends on sbp_pkg and stern_brocot_path_core_defines.svh.
`include "stern_brocot_path_core_defines.svh"

module stern_brocot_path_core_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input sbp_pkg::sbp_rsp_type rsp_data
);
   import sbp_pkg::*;

   // an error item carries no path and closes the transaction
   `SBP_ASSERT_IMPL(a_error_is_last, rsp_valid && rsp_data.error, rsp_data.last && rsp_data.run_length == 32'd0, "error item not a bare last item")

   // more items follow, so the core must still be busy
   `SBP_ASSERT_IMPL(a_mid_item_busy, rsp_valid && !rsp_data.last, busy, "non-last item while idle")

   // the last item frees the core in the same cycle
   `SBP_ASSERT_IMPL(a_last_frees, rsp_valid && rsp_data.last, !busy, "still busy on last item")

   // no item can appear in the cycle after an idle cycle
   `SBP_ASSERT_NEXT(a_no_item_from_idle, !busy, !rsp_valid, "item without a transaction in flight")

endmodule

bind stern_brocot_path_core stern_brocot_path_core_checker u_checker (.*);

>>> verif/tb_stern_brocot_path_core.sv
// Testbench for stern_brocot_path_core: sends fractions, predicts each run-length
// path item and checks every strobed item in order. Depends on sbp_pkg and the core.
`timescale 1ns / 100ps

module tb_stern_brocot_path_core;
   import sbp_pkg::*;

   localparam int OPERAND_WIDTH = 32;
   localparam int RUN_CYCLES    = OPERAND_WIDTH + 2;
   localparam int IDLE_LIMIT    = 20 * RUN_CYCLES;
   localparam int DRAIN_CYCLES  = 2 * RUN_CYCLES;
   localparam int MAX_REPORTS   = 10;
   localparam int RANDOM_ITEMS  = 108;
   localparam logic [63:0] OPERAND_MASK_WIDE = (64'd1 << OPERAND_WIDTH) - 64'd1;
   localparam logic [31:0] OPERAND_MASK      = OPERAND_MASK_WIDE[31:0];
   localparam logic DIR_LEFT  = 1'b0;
   localparam logic DIR_RIGHT = 1'b1;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   sbp_req_type req_data;
   logic        rsp_valid;
   sbp_rsp_type rsp_data;

   sbp_rsp_type expected_runs[$];
   int          mismatch_count = 0;
   int          idle_cycles = 0;
   int          burst_left = 0;

   stern_brocot_path_core #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Appends one expected item at the tail of the queue.
   function automatic void queue_run(input sbp_rsp_type item);
      expected_runs.insert(expected_runs.size(), item);
   endfunction

   // Expected path of one fraction, appended run by run.
   function automatic void predict_path(input logic [31:0] num_in, input logic [31:0] den_in);
      logic [31:0] num;
      logic [31:0] den;
      logic [31:0] run;
      logic        dir;
      int          count;
      num   = num_in & OPERAND_MASK;
      den   = den_in & OPERAND_MASK;
      count = 0;
      if (num == 0 || den == 0) begin
         queue_run('{direction: DIR_LEFT, run_length: '0, last: 1'b1, error: 1'b1});
      end else if (num == den) begin
         queue_run('{direction: DIR_LEFT, run_length: '0, last: 1'b1, error: 1'b0});
      end else begin
         // ends at g/g for a fraction not in lowest terms
         while (num != den && count < MAX_RESULTS) begin
            if (num < den) begin
               run = (den - 1) / num;
               den = den - run * num;
               dir = DIR_LEFT;
            end else begin
               run = (num - 1) / den;
               num = num - run * den;
               dir = DIR_RIGHT;
            end
            queue_run('{direction: dir, run_length: run,
                        last: (num == den) || (count == MAX_RESULTS - 1),
                        error: 1'b0});
            count++;
         end
      end
   endfunction

   function automatic logic [31:0] fibonacci(input int idx);
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] t;
      a = 0;
      b = 1;
      for (int i = 0; i < idx; i++) begin
         t = a + b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   // Leaves start high when the burst goes on, so the next call keeps it asserted.
   task automatic send_fraction(input logic [31:0] num, input logic [31:0] den);
      req_data <= '{numerator: num, denominator: den};
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      predict_path(num, den);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 20 : $urandom_range(0, 6);
      end
   endtask

   task automatic test_special_cases();
      send_fraction(32'd1, 32'd1);
      send_fraction(32'd0, 32'd0);
      send_fraction(32'd0, 32'd1);
      send_fraction(32'd1, 32'd0);
      send_fraction(32'd0, 32'hFFFF_FFFF);
      send_fraction(32'hFFFF_FFFF, 32'd0);
      send_fraction(32'd7, 32'd7);
      send_fraction(32'd6, 32'd4);
      send_fraction(32'd12, 32'd18);
   endtask

   task automatic test_extremes();
      send_fraction(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_fraction(32'd1, 32'd2);
      send_fraction(32'd2, 32'd1);
      send_fraction(32'd1, 32'hFFFF_FFFF);
      send_fraction(32'hFFFF_FFFF, 32'd1);
      send_fraction(32'hFFFF_FFFE, 32'hFFFF_FFFF);
      send_fraction(32'hFFFF_FFFF, 32'hFFFF_FFFE);
      send_fraction(32'h8000_0000, 32'h7FFF_FFFF);
      send_fraction(32'h5555_5555, 32'hAAAA_AAAA);
   endtask

   // consecutive Fibonacci numbers give the longest paths at 32 bits
   task automatic test_long_paths();
      send_fraction(fibonacci(46), fibonacci(47));
      send_fraction(fibonacci(47), fibonacci(46));
      send_fraction(fibonacci(45), fibonacci(47));
      send_fraction(fibonacci(25) * 3, fibonacci(24) * 3);
   endtask

   task automatic test_random_fractions();
      logic [31:0] num;
      logic [31:0] den;
      logic [31:0] g;
      logic [31:0] mask;
      int          w;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         case ($urandom_range(0, 9))
            4: begin
               num = $urandom_range(1, 255);
               den = $urandom_range(1, 255);
            end
            5: begin
               g   = $urandom_range(2, 1000);
               num = g * $urandom_range(1, 1 << 21);
               den = g * $urandom_range(1, 1 << 21);
            end
            6: begin
               w    = $urandom_range(1, 32);
               mask = (w == 32) ? 32'hFFFF_FFFF : (32'd1 << w) - 1;
               num  = $urandom & mask;
               den  = $urandom & mask;
            end
            7: begin
               num = $urandom_range(0, 1) ? $urandom : 32'd0;
               den = (num == 0) ? $urandom : 32'd0;
            end
            8: begin
               num = $urandom;
               den = num;
            end
            9: begin
               w   = $urandom_range(2, 46);
               num = fibonacci(w);
               den = fibonacci(w + 1);
               if ($urandom_range(0, 1)) begin
                  g   = num;
                  num = den;
                  den = g;
               end
            end
            default: begin
               num = $urandom;
               den = $urandom;
            end
         endcase
         send_fraction(num, den);
      end
   endtask

   always @(posedge clock) begin
      sbp_rsp_type want;
      if (reset || (start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (!reset && rsp_valid) begin
         if (expected_runs.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected path item: dir=%0d run=%0d last=%0d err=%0d",
                        rsp_data.direction, rsp_data.run_length, rsp_data.last,
                        rsp_data.error);
         end else begin
            want = expected_runs.pop_front();
            if (rsp_data.direction !== want.direction || rsp_data.run_length !== want.run_length
                || rsp_data.last !== want.last || rsp_data.error !== want.error) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("path item mismatch: exp dir=%0d run=%0d last=%0d err=%0d, %s",
                           want.direction, want.run_length, want.last, want.error,
                           $sformatf("got dir=%0d run=%0d last=%0d err=%0d",
                                     rsp_data.direction, rsp_data.run_length,
                                     rsp_data.last, rsp_data.error));
            end
         end
      end
   end

   // watchdog on cycles with no transaction on either side
   initial begin
      do @(posedge clock); while (idle_cycles < IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_special_cases();
      test_extremes();
      test_long_paths();
      test_random_fractions();
      start <= 1'b0;
      while (expected_runs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      #1;
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> stern_brocot_path_core.f
+incdir+rtl/core
rtl/core/sbp_pkg.sv
rtl/core/sbp_divider.sv
rtl/core/stern_brocot_path_core.sv
rtl/core/stern_brocot_path_core_checker.sv
verif/tb_stern_brocot_path_core.sv
